// ----- rtl/core/pado_pkg.sv -----
// ----------------------------------------------------------------------------
// pado_pkg
// Shared types and constants for the process alarm channel with on-delay.
// ----------------------------------------------------------------------------
package pado_pkg;

  // Width of the configuration registers and of the configuration index.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned THRESH_W   = 32;
  localparam int unsigned DELAY_W    = 32;

  // One tenth in Q0.16, applied to the threshold in deviation mode.
  localparam logic signed [14:0] TENTH_MULT = 15'sd6554;
  localparam int unsigned        TENTH_SHIFT = 16;

  typedef enum logic [2:0] {
    MODE_HIGH      = 3'd0,
    MODE_LOW       = 3'd1,
    MODE_HIGH_HIGH = 3'd2,
    MODE_LOW_LOW   = 3'd3,
    MODE_RATE      = 3'd4,
    MODE_DEVIATION = 3'd5,
    MODE_BAD_QUAL  = 3'd6,
    MODE_NONE      = 3'd7
  } pado_mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_MODE      = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_DELAY     = 2'd3
  } pado_cfg_idx_e;

  // Control handed from the evaluation stage to the timer.
  typedef struct packed {
    logic step;    // an item moves to the result register this cycle
    logic enable;  // channel enabled
    logic met;     // alarm condition holds for this item
  } pado_ctl_t;

endpackage

// ----- rtl/core/pado_cond.sv -----
// ----------------------------------------------------------------------------
// pado_cond
// Alarm condition test for one sample, and the previous-sample register.
// ----------------------------------------------------------------------------
module pado_cond
  import pado_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          enable_i,
  input  pado_mode_e                    mode_i,
  input  logic signed [THRESH_W-1:0]    threshold_i,
  input  logic signed [VALUE_WIDTH-1:0] sample_i,
  output logic                          met_o
);

  // Common compare width: room for a difference and its magnitude.
  localparam int unsigned CW = ((VALUE_WIDTH > THRESH_W) ? VALUE_WIDTH : THRESH_W) + 2;
  localparam int unsigned PW = THRESH_W + 15;

  logic signed [VALUE_WIDTH-1:0] prev_q, prev_d;
  logic signed [CW-1:0]          v_c, t_c, last_c;
  logic signed [CW-1:0]          rate_diff, rate_abs, dev_diff, dev_abs, tenth_c;
  logic signed [PW-1:0]          prod;

  always_comb begin
    v_c       = CW'(sample_i);
    t_c       = CW'(threshold_i);
    last_c    = CW'(prev_q);
    rate_diff = v_c - last_c;
    rate_abs  = rate_diff[CW-1] ? -rate_diff : rate_diff;
    dev_diff  = v_c - t_c;
    dev_abs   = dev_diff[CW-1] ? -dev_diff : dev_diff;
    prod      = PW'(threshold_i) * PW'(TENTH_MULT);
    // Arithmetic shift right floors toward minus infinity.
    tenth_c   = CW'($signed(prod[PW-1:TENTH_SHIFT]));
  end

  always_comb begin
    case (mode_i)
      MODE_HIGH, MODE_HIGH_HIGH: met_o = v_c > t_c;
      MODE_LOW, MODE_LOW_LOW:    met_o = v_c < t_c;
      MODE_RATE:                 met_o = rate_abs > t_c;
      MODE_DEVIATION:            met_o = dev_abs > tenth_c;
      default:                   met_o = 1'b0;
    endcase
  end

  // The previous sample only follows the stream while the channel is enabled.
  assign prev_d = (step_i && enable_i) ? sample_i : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ----- rtl/core/pado_timer.sv -----
// ----------------------------------------------------------------------------
// pado_timer
// On-delay timer and alarm latch; produces the fired and active flags.
// ----------------------------------------------------------------------------
module pado_timer
  import pado_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pado_ctl_t             ctl_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [DELAY_W-1:0]    delay_i,
  output logic                  fired_o,
  output logic                  active_o
);

  logic [TIME_WIDTH-1:0] start_q, start_d, start_eff, elapsed;
  logic                  latch_q, latch_d;

  always_comb begin
    // A start time of zero marks the timer as idle.
    start_eff = (start_q == '0) ? now_i : start_q;
    elapsed   = now_i - start_eff;
    start_d   = start_q;
    latch_d   = latch_q;
    fired_o   = 1'b0;
    if (!ctl_i.enable || !ctl_i.met) begin
      start_d = '0;
      latch_d = 1'b0;
    end else begin
      start_d = start_eff;
      if (elapsed >= TIME_WIDTH'(delay_i) && !latch_q) begin
        latch_d = 1'b1;
        fired_o = 1'b1;
      end
    end
    active_o = latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      latch_q <= 1'b0;
    end else if (ctl_i.step) begin
      start_q <= start_d;
      latch_q <= latch_d;
    end
  end

  fired_needs_clear_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && fired_o) |-> !latch_q)
    else $error("alarm fired while the latch was already set");

  disabled_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && !ctl_i.enable) |=> (start_q == '0 && !latch_q))
    else $error("timer or latch kept state on a disabled item");

  latch_has_running_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && latch_d && ctl_i.met && now_i != '0 && start_q == '0) |=> start_q != '0)
    else $error("timer start lost when the alarm latched");

endmodule

// ----- rtl/core/process_alarm_with_on_delay_core.sv -----
// ----------------------------------------------------------------------------
// process_alarm_with_on_delay_core
// One process-alarm channel: mode test of each sample, on-delay timer, latch.
// An accepted item waits in the input register until the result register is
// free. Throughput: one item per cycle while the result stream is not stalled;
// the condition test and timer update fit in one register-to-register stage.
// Reset clears the configuration, previous sample, timer and latch.
// ----------------------------------------------------------------------------
module process_alarm_with_on_delay_core
  import pado_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Sample stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // Fields from bit 0: sample, time_ms, zero padding.
  input  logic [((VALUE_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // Result stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // Fields from bit 0: fired, active, zero padding.
  output logic [7:0]            m_axis_tdata_o
);

  // Configuration registers.
  logic                       enable_q;
  pado_mode_e                 mode_q;
  logic signed [THRESH_W-1:0] threshold_q;
  logic [DELAY_W-1:0]         delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      mode_q      <= MODE_HIGH;
      threshold_q <= '0;
      delay_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (pado_cfg_idx_e'(cfg_addr_i))
        CFG_ENABLE:    enable_q    <= cfg_wdata_i[0];
        CFG_MODE:      mode_q      <= pado_mode_e'(cfg_wdata_i[2:0]);
        CFG_THRESHOLD: threshold_q <= cfg_wdata_i[THRESH_W-1:0];
        CFG_DELAY:     delay_q     <= cfg_wdata_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register with valid flags.
  logic                          in_vld_q;
  logic signed [VALUE_WIDTH-1:0] sample_q;
  logic [TIME_WIDTH-1:0]         time_q;
  logic                          out_vld_q;
  logic [1:0]                    out_data_q;
  logic                          out_free, step, in_take;
  logic                          met, fired, active;
  pado_ctl_t                     ctl;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= s_axis_tdata_i[VALUE_WIDTH-1:0];
      time_q   <= s_axis_tdata_i[VALUE_WIDTH+TIME_WIDTH-1:VALUE_WIDTH];
    end
    if (step) begin
      out_data_q <= {active, fired};
    end
  end

  pado_cond #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_cond (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .enable_i   (enable_q),
    .mode_i     (mode_q),
    .threshold_i(threshold_q),
    .sample_i   (sample_q),
    .met_o      (met)
  );

  assign ctl.step   = step;
  assign ctl.enable = enable_q;
  assign ctl.met    = met;

  pado_timer #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .now_i   (time_q),
    .delay_i (delay_q),
    .fired_o (fired),
    .active_o(active)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_data_q};

  fired_implies_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_data_q[0] && !out_data_q[1]))
    else $error("fired result without an active latch");

  disabled_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !enable_q) |=> (out_data_q == 2'b00))
    else $error("disabled channel produced a nonzero result");

  no_loss_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !step)
    else $error("result register overwritten while stalled");

  input_never_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> in_vld_q)
    else $error("pending item lost from the input register");

endmodule
